// ----- sv/acc_pkg.sv -----
// ----------------------------------------------------------------------------
// acc_pkg
// shared types and constants of the alarm clock controller
// ----------------------------------------------------------------------------
package acc_pkg;

	localparam int NUM_ALARMS = 5;
	localparam int SLOT_W     = 3;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(NUM_ALARMS);

	localparam logic [18:0] ALARM_TIMEOUT_MS   = 19'd300000;
	localparam logic [18:0] ALARM_EL_MAX       = 19'h7FFFF;
	localparam logic [8:0]  ALARM_BLINK_PERIOD = 9'd501;
	localparam logic [7:0]  ALERT_BLINK_PERIOD = 8'd251;
	localparam logic [12:0] ALERT_LEN_MS       = 13'd5000;
	localparam logic [12:0] LONG_PRESS_MS      = 13'd5000;
	localparam logic [12:0] MS13_MAX           = 13'h1FFF;
	localparam logic [5:0]  DEBOUNCE_MS        = 6'd50;
	localparam logic [5:0]  DEBOUNCE_MAX       = 6'd63;
	localparam logic [9:0]  MS_PER_S_LAST      = 10'd999;
	localparam logic [15:0] SECS_PER_MIN       = 16'd60;
	localparam logic [5:0]  ALARM_SEC_WINDOW   = 6'd5;
	localparam logic [2:0]  WEEKDAY_INVALID    = 3'd7;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	typedef enum logic [1:0] {
		MODE_NORMAL    = 2'd0,
		MODE_RINGING   = 2'd1,
		MODE_COUNTDOWN = 2'd2
	} mode_t;

	typedef struct packed {
		logic       en;
		logic [6:0] days;
		logic [4:0] hour;
		logic [5:0] minute;
	} slot_t;

	typedef struct packed {
		logic       op;
		logic [4:0] clock_hour;
		logic [5:0] clock_minute;
		logic [5:0] clock_second;
		logic [2:0] weekday;
		logic       button_level;
		logic [9:0] duration_minutes;
	} item_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic              buzzer_on;
		logic [SLOT_W-1:0] ringing_slot;
		logic [15:0]       remaining_seconds;
		logic              timer_alert;
		logic              reset_request;
		logic              start_rejected;
	} result_t;

endpackage

// ----- sv/acc_regs.sv -----
// ----------------------------------------------------------------------------
// acc_regs
// apb register file holding the alarm slots
// ----------------------------------------------------------------------------
module acc_regs
	import acc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output slot_t             slots [NUM_ALARMS]
);

	slot_t      slots_q [NUM_ALARMS];
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign slots  = slots_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ALARMS; i++) begin
				slots_q[i] <= '0;
			end
		end else if (wr_en) begin
			for (int i = 0; i < NUM_ALARMS; i++) begin
				if (idx == 3'(i)) begin
					slots_q[i] <= slot_t'(pwdata[18:0]);
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		for (int i = 0; i < NUM_ALARMS; i++) begin
			if (idx == 3'(i)) begin
				prdata = DATA_W'(slots_q[i]);
			end
		end
	end

endmodule

// ----- sv/acc_step.sv -----
// ----------------------------------------------------------------------------
// acc_step
// controller state and the per-request update logic
// ----------------------------------------------------------------------------
module acc_step
	import acc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  item_t   item,
	input  slot_t   slots [NUM_ALARMS],
	output result_t res
);

	typedef struct packed {
		mode_t             mode;
		logic [SLOT_W-1:0] ring_idx;
		logic [18:0]       a_el;
		logic [8:0]        a_bl;
		logic              a_ph;
		logic [9:0]        cd_ms;
		logic [15:0]       cd_left;
		logic              cd_run;
		logic              al_f;
		logic [12:0]       al_el;
		logic [7:0]        al_bl;
		logic              al_ph;
		logic              last_b;
		logic [5:0]        db;
		logic [12:0]       pr;
	} st_t;

	st_t                 st_q;
	st_t                 nx;
	logic                rst_req;
	logic                rej;
	logic [NUM_ALARMS-1:0] hit;

	always_comb begin
		logic [7:0] mask;
		for (int i = 0; i < NUM_ALARMS; i++) begin
			mask   = {1'b0, slots[i].days};
			hit[i] = slots[i].en && (slots[i].hour == item.clock_hour)
				&& (slots[i].minute == item.clock_minute)
				&& (item.clock_second < ALARM_SEC_WINDOW)
				&& (item.weekday != WEEKDAY_INVALID) && mask[item.weekday];
		end
	end

	always_comb begin
		logic             found;
		logic [SLOT_W-1:0] first;
		nx      = st_q;
		rst_req = 1'b0;
		rej     = 1'b0;
		found   = 1'b0;
		first   = SLOT_NONE;
		for (int i = NUM_ALARMS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found = 1'b1;
				first = SLOT_W'(i);
			end
		end
		if (item.op == OP_START) begin
			if (st_q.cd_run) begin
				rej = 1'b1;
			end else begin
				nx.cd_left  = 16'(item.duration_minutes) * SECS_PER_MIN;
				nx.cd_ms    = '0;
				nx.cd_run   = 1'b1;
				nx.mode     = MODE_COUNTDOWN;
				nx.ring_idx = SLOT_NONE;
				nx.a_el     = '0;
				nx.a_bl     = '0;
				nx.a_ph     = 1'b0;
			end
		end else begin
			// alert timing
			if (nx.al_f) begin
				if (nx.al_el != MS13_MAX) nx.al_el = nx.al_el + 13'd1;
				if (nx.al_el >= ALERT_LEN_MS) begin
					nx.al_f  = 1'b0;
					nx.al_el = '0;
					nx.al_bl = '0;
					nx.al_ph = 1'b0;
				end else begin
					nx.al_bl = nx.al_bl + 8'd1;
					if (nx.al_bl >= ALERT_BLINK_PERIOD) begin
						nx.al_bl = '0;
						nx.al_ph = !nx.al_ph;
					end
				end
			end
			// button
			if (nx.db != DEBOUNCE_MAX) nx.db = nx.db + 6'd1;
			if (nx.pr != MS13_MAX) nx.pr = nx.pr + 13'd1;
			if ((item.button_level != nx.last_b) && (nx.db >= DEBOUNCE_MS)) begin
				nx.db = '0;
				if (!item.button_level) begin
					nx.pr = '0;
				end else if (nx.pr >= LONG_PRESS_MS) begin
					rst_req = 1'b1;
				end else if (nx.mode == MODE_RINGING) begin
					nx.mode     = MODE_NORMAL;
					nx.ring_idx = SLOT_NONE;
					nx.a_el     = '0;
					nx.a_bl     = '0;
					nx.a_ph     = 1'b0;
					nx.cd_run   = 1'b0;
					nx.cd_ms    = '0;
					nx.cd_left  = '0;
					nx.al_f     = 1'b0;
					nx.al_el    = '0;
					nx.al_bl    = '0;
					nx.al_ph    = 1'b0;
				end else if ((nx.mode == MODE_NORMAL) && nx.al_f) begin
					nx.al_f  = 1'b0;
					nx.al_el = '0;
					nx.al_bl = '0;
					nx.al_ph = 1'b0;
				end
			end
			nx.last_b = item.button_level;
			// mode work
			case (nx.mode)
				MODE_NORMAL: begin
					if (found) begin
						nx.mode     = MODE_RINGING;
						nx.ring_idx = first;
						nx.a_el     = '0;
						nx.a_bl     = ALARM_BLINK_PERIOD - 9'd1;
						nx.a_ph     = 1'b0;
					end
				end
				MODE_COUNTDOWN: begin
					if (nx.cd_run) begin
						if (nx.cd_ms == MS_PER_S_LAST) begin
							nx.cd_ms = '0;
							if (nx.cd_left != '0) nx.cd_left = nx.cd_left - 16'd1;
						end else begin
							nx.cd_ms = nx.cd_ms + 10'd1;
						end
						if (nx.cd_left == '0) begin
							nx.cd_run  = 1'b0;
							nx.cd_ms   = '0;
							nx.al_f    = 1'b1;
							nx.al_el   = '0;
							nx.al_bl   = ALERT_BLINK_PERIOD - 8'd1;
							nx.al_ph   = 1'b0;
						end
					end
					if (!nx.cd_run) nx.mode = MODE_NORMAL;
				end
				MODE_RINGING: begin
					if (nx.a_el != ALARM_EL_MAX) nx.a_el = nx.a_el + 19'd1;
					nx.a_bl = nx.a_bl + 9'd1;
					if (nx.a_bl >= ALARM_BLINK_PERIOD) begin
						nx.a_bl = '0;
						nx.a_ph = !nx.a_ph;
					end
					if (nx.a_el > ALARM_TIMEOUT_MS) begin
						nx.mode     = MODE_NORMAL;
						nx.ring_idx = SLOT_NONE;
						nx.a_el     = '0;
						nx.a_bl     = '0;
						nx.a_ph     = 1'b0;
						nx.cd_run   = 1'b0;
						nx.cd_ms    = '0;
						nx.cd_left  = '0;
						nx.al_f     = 1'b0;
						nx.al_el    = '0;
						nx.al_bl    = '0;
						nx.al_ph    = 1'b0;
					end
				end
				default: begin
					nx.mode = MODE_NORMAL;
				end
			endcase
		end
		res.mode              = nx.mode;
		res.buzzer_on         = ((nx.mode == MODE_RINGING) && nx.a_ph) || (nx.al_f && nx.al_ph);
		res.ringing_slot      = nx.ring_idx;
		res.remaining_seconds = nx.cd_run ? nx.cd_left : 16'd0;
		res.timer_alert       = nx.al_f;
		res.reset_request     = rst_req;
		res.start_rejected    = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: MODE_NORMAL, ring_idx: SLOT_NONE, last_b: 1'b1,
				db: DEBOUNCE_MAX, default: '0};
		end else if (adv) begin
			st_q <= nx;
		end
	end

`ifndef NO_ASSERTIONS
	a_ring_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode == MODE_RINGING) == (st_q.ring_idx != SLOT_NONE))
		else $error("ringing slot disagrees with mode");
	a_cd_mode: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.cd_run |-> (st_q.mode == MODE_COUNTDOWN))
		else $error("countdown running outside countdown mode");
	a_alert_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.al_f |-> (st_q.al_el == '0) && !st_q.al_ph)
		else $error("alert timing left over");
	a_ms_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.cd_ms <= MS_PER_S_LAST)
		else $error("millisecond counter out of range");
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (item.op == OP_START) |=> st_q.cd_run)
		else $error("start request left no countdown running");
`endif

endmodule

// ----- sv/alarm_clock_controller_core.sv -----
// ----------------------------------------------------------------------------
// alarm_clock_controller_core
// alarm, countdown and button controller driven by millisecond requests
// ----------------------------------------------------------------------------
// One request per clock cycle is taken when the result side keeps up: a
// request is captured in an input register, the whole update of the alarm,
// countdown, alert and button state is done combinationally from there into
// the result register, and the result is offered from that register.
// The alarm slots are written over apb at byte addresses 0x00 to 0x10 and
// read back at the same addresses; write them only while no request is in
// flight. There is no start-up pass after reset.
module alarm_clock_controller_core
	import acc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// hour[4:0] minute[10:5] second[16:11] weekday[19:17] button[20] duration[30:21]
	input  logic [31:0]       s_tdata,
	// op[0]
	input  logic              s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// mode[1:0] buzzer[2] slot[5:3] remaining[21:6] alert[22] reset_req[23] rejected[24]
	output logic [31:0]       m_tdata,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	item_t   item_s1;
	logic    vld_s1;
	result_t res;
	result_t res_s2;
	logic    vld_s2;
	logic    adv;
	logic    s_acc;
	slot_t   slots [NUM_ALARMS];

	assign adv      = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv;
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = vld_s2;
	assign m_tdata  = {7'd0, res_s2.start_rejected, res_s2.reset_request, res_s2.timer_alert,
		res_s2.remaining_seconds, res_s2.ringing_slot, res_s2.buzzer_on, res_s2.mode};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_acc) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				vld_s2 <= 1'b1;
			end else if (m_tready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			item_s1.op               <= s_tuser;
			item_s1.clock_hour       <= s_tdata[4:0];
			item_s1.clock_minute     <= s_tdata[10:5];
			item_s1.clock_second     <= s_tdata[16:11];
			item_s1.weekday          <= s_tdata[19:17];
			item_s1.button_level     <= s_tdata[20];
			item_s1.duration_minutes <= s_tdata[30:21];
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	acc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.slots   (slots)
	);

	acc_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.slots  (slots),
		.res    (res)
	);

endmodule
